### src/bdpc_pkg.sv
`default_nettype none

package bdpc_pkg;

  localparam int MAX_BUTTONS_DEF = 8;
  localparam int TIME_BITS_DEF   = 32;

  localparam int PIN_W   = 8;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 4;
  localparam int MS_W    = 16;
  localparam int KIND_W  = 2;
  localparam int BTN_W   = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd2;

  localparam logic [CNT_W-1:0] BUTTON_COUNT_RST = 4'd8;
  localparam logic [MS_W-1:0]  DEBOUNCE_MS_RST  = 16'd20;
  localparam logic [MS_W-1:0]  LONG_PRESS_RST   = 16'd1000;

  localparam logic [KIND_W-1:0] EV_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] EV_SHORT = 2'd1;
  localparam logic [KIND_W-1:0] EV_LONG  = 2'd2;

endpackage

`default_nettype wire

### src/button_debounce_press_classifier_core.sv
// Debounces up to MAX_BUTTONS active-low buttons and classifies short and long
// presses. Each accepted item is one poll: pin levels plus a millisecond time.
// The per-button state lives in a single synchronous memory, and the block
// visits one button per cycle. The visit stops at the first button that yields
// an event, so a poll visits between one and the button count of buttons (none
// when the count is zero). After acceptance each visited button's entry is read
// and then evaluated; the result goes through a final state that loads it
// into the output register once the output is free, and only after that
// does the block return to idle and accept the next poll. Exactly one result
// item is produced per poll, with event kind none when nothing happened. The
// block takes one poll at a time; a new poll is accepted while the previous
// result still waits at the output, and its own result holds until that one is
// taken. Configuration writes are taken at any time but must only be issued
// while the block is idle.
`default_nettype none

module button_debounce_press_classifier_core #(
  parameter int MAX_BUTTONS = bdpc_pkg::MAX_BUTTONS_DEF,
  parameter int TIME_BITS   = bdpc_pkg::TIME_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [bdpc_pkg::PIN_W-1:0]       in_pin_levels,
  input  wire logic [bdpc_pkg::TIME_W-1:0]      in_time_ms,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [bdpc_pkg::KIND_W-1:0]           out_event_kind,
  output logic [bdpc_pkg::BTN_W-1:0]            out_event_button,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bdpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bdpc_pkg::MS_W-1:0]        cfg_data
);

  localparam int IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int NCNT_W = $clog2(MAX_BUTTONS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PROC = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  typedef struct packed {
    logic                 stable;
    logic                 last_raw;
    logic                 long_done;
    logic [TIME_BITS-1:0] chg_time;
    logic [TIME_BITS-1:0] press_time;
  } entry_t;

  logic [bdpc_pkg::CNT_W-1:0] cfg_count_r;
  logic [bdpc_pkg::MS_W-1:0]  cfg_deb_r;
  logic [bdpc_pkg::MS_W-1:0]  cfg_long_r;

  logic [1:0]                 state_r, state_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [bdpc_pkg::PIN_W-1:0] pins_r;
  logic [TIME_BITS-1:0]       now_r;
  logic [bdpc_pkg::KIND_W-1:0] res_kind_r, res_kind_nxt;
  logic [bdpc_pkg::BTN_W-1:0]  res_btn_r, res_btn_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [bdpc_pkg::KIND_W-1:0] out_kind_r;
  logic [bdpc_pkg::BTN_W-1:0]  out_btn_r;

  entry_t               mem [MAX_BUTTONS];
  logic [MAX_BUTTONS-1:0] vld_r;
  entry_t               rd_data_r;
  logic                 rd_vld_r;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  entry_t               wr_data;

  logic [NCNT_W-1:0]    cnt;
  logic                 in_acc;
  logic                 out_load;
  logic                 is_last;
  logic                 raw;
  logic [31:0]          idx_ext;
  entry_t               ent;
  logic [bdpc_pkg::KIND_W-1:0] ev_kind;

  assign cfg_ready        = 1'b1;
  assign in_ready         = (state_r == ST_IDLE);
  assign in_acc           = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_event_button = out_btn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= bdpc_pkg::BUTTON_COUNT_RST;
      cfg_deb_r   <= bdpc_pkg::DEBOUNCE_MS_RST;
      cfg_long_r  <= bdpc_pkg::LONG_PRESS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bdpc_pkg::REG_BUTTON_COUNT: cfg_count_r <= cfg_data[bdpc_pkg::CNT_W-1:0];
        bdpc_pkg::REG_DEBOUNCE_MS:  cfg_deb_r   <= cfg_data;
        bdpc_pkg::REG_LONG_PRESS:   cfg_long_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(cfg_count_r) > 32'(MAX_BUTTONS)) begin
      cnt = NCNT_W'(MAX_BUTTONS);
    end else begin
      cnt = NCNT_W'(cfg_count_r);
    end
  end

  // One button is evaluated per cycle from the entry read in the cycle before.
  always_comb begin
    idx_ext = 32'(idx_r);
    raw     = (idx_ext < 32'(bdpc_pkg::PIN_W)) && !pins_r[idx_ext[2:0]];
    ent     = rd_vld_r ? rd_data_r : '0;
    wr_data = ent;
    ev_kind = bdpc_pkg::EV_NONE;
    if (raw != ent.last_raw) begin
      wr_data.last_raw = raw;
      wr_data.chg_time = now_r;
    end
    if ((TIME_BITS'(now_r - wr_data.chg_time) >= TIME_BITS'(cfg_deb_r)) &&
        (raw != ent.stable)) begin
      wr_data.stable = raw;
      if (raw) begin
        wr_data.press_time = now_r;
        wr_data.long_done  = 1'b0;
      end else if (!ent.long_done) begin
        ev_kind = bdpc_pkg::EV_SHORT;
      end
    end
    if ((ev_kind == bdpc_pkg::EV_NONE) && wr_data.stable && !wr_data.long_done &&
        (TIME_BITS'(now_r - wr_data.press_time) >= TIME_BITS'(cfg_long_r))) begin
      wr_data.long_done = 1'b1;
      ev_kind = bdpc_pkg::EV_LONG;
    end
    is_last = ((idx_ext + 32'd1) == 32'(cnt));
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    res_kind_nxt  = res_kind_r;
    res_btn_nxt   = res_btn_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_kind_nxt = bdpc_pkg::EV_NONE;
          res_btn_nxt  = '0;
          idx_nxt      = '0;
          if (cnt == '0) begin
            state_nxt = ST_FIN;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_nxt = ST_PROC;
          end
        end
      end
      ST_PROC: begin
        wr_en = 1'b1;
        if ((ev_kind != bdpc_pkg::EV_NONE) || is_last) begin
          res_kind_nxt = ev_kind;
          res_btn_nxt  = (ev_kind != bdpc_pkg::EV_NONE) ? idx_ext[2:0] : '0;
          state_nxt    = ST_FIN;
        end else begin
          idx_nxt   = IDX_W'(idx_ext + 32'd1);
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(idx_ext + 32'd1);
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      if (wr_en) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_kind_r <= res_kind_nxt;
    res_btn_r  <= res_btn_nxt;
    if (in_acc) begin
      pins_r <= in_pin_levels;
      now_r  <= TIME_BITS'(in_time_ms);
    end
    if (out_load) begin
      out_kind_r <= res_kind_r;
      out_btn_r  <= res_btn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  a_wr_only_proc: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_PROC))
    else $error("state memory written outside a button visit");

  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("accepted poll did not start processing");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROC) |-> (32'(idx_r) < 32'(cnt)))
    else $error("button index beyond the button count");

  a_none_btn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == bdpc_pkg::EV_NONE)) |-> (out_btn_r == '0))
    else $error("no-event result carries a button index");

endmodule

`default_nettype wire

### dv/tb_button_debounce_press_classifier_core.sv
`default_nettype none

module tb_button_debounce_press_classifier_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bdpc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PHASES = 10;
  localparam int POLLS_PER_PHASE = 90;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [bdpc_pkg::KIND_W-1:0] kind;
    logic [bdpc_pkg::BTN_W-1:0]  btn;
  } press_report_t;

  typedef struct {
    bit                             is_cfg;
    logic [bdpc_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [bdpc_pkg::MS_W-1:0]      reg_val;
    logic [bdpc_pkg::PIN_W-1:0]     pins;
    logic [bdpc_pkg::TIME_W-1:0]    stamp;
    bit                             known;
    logic [bdpc_pkg::KIND_W-1:0]    kind;
    logic [bdpc_pkg::BTN_W-1:0]     btn;
  } poll_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [bdpc_pkg::PIN_W-1:0] in_pin_levels = '1;
  logic [bdpc_pkg::TIME_W-1:0] in_time_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [bdpc_pkg::KIND_W-1:0] out_event_kind;
  logic [bdpc_pkg::BTN_W-1:0] out_event_button;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bdpc_pkg::MS_W-1:0] cfg_data = '0;

  button_debounce_press_classifier_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pin_levels    (in_pin_levels),
    .in_time_ms       (in_time_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_event_button (out_event_button),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the debouncer: registers and per-button state.
  logic [bdpc_pkg::CNT_W-1:0]  cfg_count = bdpc_pkg::BUTTON_COUNT_RST;
  logic [bdpc_pkg::MS_W-1:0]   cfg_debounce = bdpc_pkg::DEBOUNCE_MS_RST;
  logic [bdpc_pkg::MS_W-1:0]   cfg_long = bdpc_pkg::LONG_PRESS_RST;
  logic [7:0]                  btn_down = '0;
  logic [7:0]                  raw_down = '0;
  logic [7:0]                  long_sent = '0;
  logic [bdpc_pkg::TIME_W-1:0] raw_edge_ms [8] = '{default: '0};
  logic [bdpc_pkg::TIME_W-1:0] press_ms [8] = '{default: '0};

  press_report_t pending_reports[$];
  poll_step_t    script[$];

  int errors = 0;
  int polls_sent = 0;
  int shorts_seen = 0;
  int longs_seen = 0;
  int cycles = 0;
  int rx_hold = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit cfg_open;
  logic [bdpc_pkg::PIN_W-1:0] hold_pins = '1;
  logic [bdpc_pkg::TIME_W-1:0] clock_ms = '0;

  function automatic void classify_poll(input logic [bdpc_pkg::PIN_W-1:0] pins,
                                        input logic [bdpc_pkg::TIME_W-1:0] now,
                                        output logic [bdpc_pkg::KIND_W-1:0] kind,
                                        output logic [bdpc_pkg::BTN_W-1:0] btn);
    int span;
    logic raw;
    span = (cfg_count > 8) ? 8 : int'(cfg_count);
    kind = bdpc_pkg::EV_NONE;
    btn = '0;
    for (int i = 0; i < span; i++) begin
      raw = ~pins[i];
      if (raw != raw_down[i]) begin
        raw_down[i] = raw;
        raw_edge_ms[i] = now;
      end
      if (bdpc_pkg::TIME_W'(now - raw_edge_ms[i]) >= bdpc_pkg::TIME_W'(cfg_debounce) &&
          raw != btn_down[i]) begin
        btn_down[i] = raw;
        if (raw) begin
          press_ms[i] = now;
          long_sent[i] = 1'b0;
        end else if (!long_sent[i]) begin
          kind = bdpc_pkg::EV_SHORT;
          btn = bdpc_pkg::BTN_W'(i);
          return;
        end
      end
      if (btn_down[i] && !long_sent[i] &&
          bdpc_pkg::TIME_W'(now - press_ms[i]) >= bdpc_pkg::TIME_W'(cfg_long)) begin
        long_sent[i] = 1'b1;
        kind = bdpc_pkg::EV_LONG;
        btn = bdpc_pkg::BTN_W'(i);
        return;
      end
    end
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_poll(input logic [bdpc_pkg::PIN_W-1:0] pins,
                                   input logic [bdpc_pkg::TIME_W-1:0] stamp);
    poll_step_t s;
    s = '{default: '0};
    s.pins = pins;
    s.stamp = stamp;
    script.push_back(s);
  endfunction

  function automatic void add_known(input logic [bdpc_pkg::PIN_W-1:0] pins,
                                    input logic [bdpc_pkg::TIME_W-1:0] stamp,
                                    input logic [bdpc_pkg::KIND_W-1:0] kind,
                                    input logic [bdpc_pkg::BTN_W-1:0] btn);
    poll_step_t s;
    s = '{default: '0};
    s.pins = pins;
    s.stamp = stamp;
    s.known = 1'b1;
    s.kind = kind;
    s.btn = btn;
    script.push_back(s);
  endfunction

  function automatic void add_cfg(input logic [bdpc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [bdpc_pkg::MS_W-1:0] val);
    poll_step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    script.push_back(s);
  endfunction

  function automatic logic [bdpc_pkg::TIME_W-1:0] pick_step();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(1, 5);
    if (r < 6) return bdpc_pkg::TIME_W'(cfg_debounce) + $urandom_range(0, 3);
    if (r < 8) return bdpc_pkg::TIME_W'(cfg_long) + $urandom_range(0, 3);
    if (r < 9) return $urandom_range(0, 50);
    return $urandom_range(0, 2000);
  endfunction

  task automatic send_poll(input logic [bdpc_pkg::PIN_W-1:0] pins,
                           input logic [bdpc_pkg::TIME_W-1:0] stamp,
                           input bit known, input logic [bdpc_pkg::KIND_W-1:0] kind,
                           input logic [bdpc_pkg::BTN_W-1:0] btn);
    int gap;
    press_report_t rpt;
    gap = (!tx_steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    classify_poll(pins, stamp, rpt.kind, rpt.btn);
    if (known) begin
      rpt.kind = kind;
      rpt.btn = btn;
    end
    pending_reports.push_back(rpt);
    in_valid <= 1'b1;
    in_pin_levels <= pins;
    in_time_ms <= stamp;
    polls_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic cfg_write(input logic [bdpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdpc_pkg::MS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bdpc_pkg::REG_BUTTON_COUNT: cfg_count = val[bdpc_pkg::CNT_W-1:0];
      bdpc_pkg::REG_DEBOUNCE_MS:  cfg_debounce = val;
      bdpc_pkg::REG_LONG_PRESS:   cfg_long = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic random_poll();
    logic [bdpc_pkg::PIN_W-1:0] pins;
    int r, k, j, span;
    r = $urandom_range(0, 99);
    span = (cfg_count == 0) ? 1 : (cfg_count > 8) ? 8 : int'(cfg_count);
    if (r < 75) begin
      k = $urandom_range(0, 99);
      j = $urandom_range(0, span - 1);
      if (k < 20) hold_pins[j] = ~hold_pins[j];
      pins = hold_pins;
      if (k >= 20 && k < 30) pins[j] = ~pins[j];
      clock_ms = clock_ms + pick_step();
    end else if (r < 87) begin
      pins = bdpc_pkg::PIN_W'($urandom);
      clock_ms = clock_ms + $urandom_range(0, 1000);
    end else if (r < 95) begin
      pins = hold_pins;
      clock_ms = (r < 91) ? bdpc_pkg::TIME_W'($urandom) :
                            32'hFFFF_FFFF - $urandom_range(0, 3000);
    end else begin
      pins = bdpc_pkg::PIN_W'($urandom);
    end
    send_poll(pins, clock_ms, 1'b0, bdpc_pkg::EV_NONE, '0);
  endtask

  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      rx_hold <= idle_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    press_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        if (errors < 10)
          $display("%0t: result with none pending: kind %0d button %0d",
                   $realtime, out_event_kind, out_event_button);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (out_event_kind !== want.kind || out_event_button !== want.btn) begin
          if (errors < 10)
            $display("%0t: mismatch: expected kind %0d button %0d, got kind %0d button %0d",
                     $realtime, want.kind, want.btn, out_event_kind, out_event_button);
          errors++;
        end
      end
      if (out_event_kind == bdpc_pkg::EV_SHORT) shorts_seen++;
      if (out_event_kind == bdpc_pkg::EV_LONG) longs_seen++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending", cycles,
               pending_reports.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase_cnt [PHASES];
    int unsigned phase_db  [PHASES];
    int unsigned phase_lp  [PHASES];
    phase_cnt = '{8, 8, 1, 0, 15, 12, 0, 8, 5, 0};
    phase_db  = '{20, 0, 65535, 5, 3, 0, 0, 65535, 2, 0};
    phase_lp  = '{1000, 0, 65535, 10, 50, 100, 0, 0, 65535, 0};

    add_known(8'hFF, 32'd0,    bdpc_pkg::EV_NONE,  3'd0);
    add_known(8'hFE, 32'd100,  bdpc_pkg::EV_NONE,  3'd0);
    add_known(8'hFE, 32'd120,  bdpc_pkg::EV_NONE,  3'd0);
    add_known(8'hFF, 32'd130,  bdpc_pkg::EV_NONE,  3'd0);
    add_known(8'hFF, 32'd150,  bdpc_pkg::EV_SHORT, 3'd0);
    add_known(8'h7F, 32'd200,  bdpc_pkg::EV_NONE,  3'd0);
    add_known(8'h7F, 32'd220,  bdpc_pkg::EV_NONE,  3'd0);
    add_known(8'h7F, 32'd1220, bdpc_pkg::EV_LONG,  3'd7);
    add_poll (8'hFF, 32'd1230);
    add_known(8'hFF, 32'd1250, bdpc_pkg::EV_NONE,  3'd0);
    add_poll (8'h00, 32'd2000);
    add_poll (8'h00, 32'd2020);
    add_known(8'h00, 32'd3020, bdpc_pkg::EV_LONG,  3'd0);
    add_known(8'h00, 32'd3020, bdpc_pkg::EV_LONG,  3'd1);
    add_poll (8'hFF, 32'hFFFF_FFF0);
    add_poll (8'hFF, 32'h0000_0004);
    add_cfg  (REG_UNUSED, 16'hFFFF);
    add_cfg  (bdpc_pkg::REG_BUTTON_COUNT, 16'd0);
    add_known(8'h00, 32'd5000, bdpc_pkg::EV_NONE,  3'd0);
    add_cfg  (bdpc_pkg::REG_BUTTON_COUNT, 16'd15);
    add_cfg  (bdpc_pkg::REG_DEBOUNCE_MS, 16'd0);
    add_cfg  (bdpc_pkg::REG_LONG_PRESS, 16'd0);
    add_poll (8'hFF, 32'd6000);
    add_poll (8'hFE, 32'd6001);
    add_poll (8'hFF, 32'd6002);
    add_cfg  (bdpc_pkg::REG_DEBOUNCE_MS, 16'hFFFF);
    add_cfg  (bdpc_pkg::REG_LONG_PRESS, 16'hFFFF);
    add_poll (8'h00, 32'hFFFF_FFFF);
    add_poll (8'h00, 32'h0000_FFFE);
    add_cfg  (bdpc_pkg::REG_BUTTON_COUNT, 16'hFFF1);
    add_poll (8'h00, 32'd1234);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    cfg_open = 1'b0;
    foreach (script[s]) begin
      if (script[s].is_cfg) begin
        if (!cfg_open) wait_idle();
        cfg_write(script[s].reg_idx, script[s].reg_val);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_poll(script[s].pins, script[s].stamp, script[s].known,
                  script[s].kind, script[s].btn);
      end
    end

    phase_cnt[6] = $urandom_range(0, 15);
    phase_db[6] = $urandom_range(0, 40);
    phase_lp[6] = $urandom_range(0, 300);
    phase_cnt[9] = $urandom_range(1, 8);
    phase_db[9] = $urandom_range(0, 65535);
    phase_lp[9] = $urandom_range(0, 65535);
    clock_ms = 32'd10000;

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      cfg_write(bdpc_pkg::REG_BUTTON_COUNT, {12'($urandom), 4'(phase_cnt[ph])});
      cfg_write(bdpc_pkg::REG_DEBOUNCE_MS, bdpc_pkg::MS_W'(phase_db[ph]));
      cfg_write(bdpc_pkg::REG_LONG_PRESS, bdpc_pkg::MS_W'(phase_lp[ph]));
      if (ph % 3 == 0) cfg_write(REG_UNUSED, bdpc_pkg::MS_W'($urandom));
      cfg_valid <= 1'b0;
      tx_steady = (ph % 4 == 1);
      rx_steady = (ph % 4 == 2);
      for (int n = 0; n < POLLS_PER_PHASE; n++) random_poll();
    end

    wait_idle();
    $display("Sent %0d polls over %0d register settings; saw %0d short and %0d long presses.",
             polls_sent, PHASES + 1, shorts_seen, longs_seen);
    $display("Mismatches: %0d.", errors);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### button_debounce_press_classifier_core.f
src/bdpc_pkg.sv
src/button_debounce_press_classifier_core.sv
dv/tb_button_debounce_press_classifier_core.sv
